// ===== rtl/world_to_pixel_projection_macros.svh =====
// Assertion macros shared by the projection block.
`ifndef WORLD_TO_PIXEL_PROJECTION_MACROS_SVH
`define WORLD_TO_PIXEL_PROJECTION_MACROS_SVH

// Clocked assertion that is off while reset is held.
`define WTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define WTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/wtp_pkg.sv =====
// Shared types and constants of the world to pixel projection block.
package wtp_pkg;

  localparam int unsigned PoseWords = 12;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);
  localparam int unsigned NumW = 63;
  localparam int unsigned DivW = 31;

  localparam logic OpLoad = 1'b0;
  localparam logic OpProject = 1'b1;

  localparam logic [1:0] RegFocalX = 2'd0;
  localparam logic [1:0] RegFocalY = 2'd1;
  localparam logic [1:0] RegCenterX = 2'd2;
  localparam logic [1:0] RegCenterY = 2'd3;

  // Camera-frame point handed from the front to the back.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic               bad;
  } cam_t;

  // Saturates a 66-bit signed value to 32 bits; bit 32 flags overflow.
  function automatic logic [32:0] sat66(input logic signed [65:0] x);
    logic [32:0] r;
    r = {1'b0, x[31:0]};
    if (x[65:31] != '0 && x[65:31] != '1) begin
      r = x[65] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
    end
    return r;
  endfunction

endpackage

// ===== rtl/wtp_front.sv =====
// Front end: takes items, holds the pose and forms camera-frame points.
module wtp_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [3:0]                  pose_index_i,
  input  logic signed [31:0]          pose_value_i,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  input  logic signed [31:0]          point_z_i,
  input  logic [wtp_pkg::QCntW-1:0]   q_count_i,
  output logic                        push_o,
  output wtp_pkg::cam_t               push_data_o
);

  logic signed [31:0] pose_q [wtp_pkg::PoseWords];
  logic signed [63:0] prod_q [9];
  logic               s1_valid_q;
  logic               accept;
  logic signed [31:0] pt [3];
  logic signed [65:0] acc [3];
  logic [32:0]        sat [3];

  assign in_ready_o = (32'(q_count_i) + 32'(s1_valid_q)) < wtp_pkg::QDepth;
  assign accept = in_valid_i && in_ready_o;
  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  // The diagonal words of the rotation reset to one, all others to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 12; i++) begin
        pose_q[i] <= (i == 0 || i == 5 || i == 10) ? 32'(1) << FRAC_BITS : '0;
      end
    end else if (accept && op_i == wtp_pkg::OpLoad &&
                 32'(pose_index_i) < wtp_pkg::PoseWords) begin
      pose_q[pose_index_i] <= pose_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && op_i == wtp_pkg::OpProject;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r*3+c] <= 64'(pose_q[r*4+c]) * 64'(pt[c]);
      end
    end
  end

  // Arithmetic shift floors each product; the sum is kept exact.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 66'(pose_q[r*4+3]) + 66'(prod_q[r*3] >>> FRAC_BITS)
             + 66'(prod_q[r*3+1] >>> FRAC_BITS) + 66'(prod_q[r*3+2] >>> FRAC_BITS);
      sat[r] = wtp_pkg::sat66(acc[r]);
    end
  end

  assign push_o = s1_valid_q;
  assign push_data_o.cx = sat[0][31:0];
  assign push_data_o.cy = sat[1][31:0];
  assign push_data_o.cz = sat[2][31:0];
  assign push_data_o.bad = sat[0][32] | sat[1][32] | sat[2][32];

endmodule

// ===== rtl/wtp_fifo.sv =====
// Short queue of camera-frame points between front and back.
`include "world_to_pixel_projection_macros.svh"
module wtp_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  wtp_pkg::cam_t             push_data_i,
  input  logic                      pop_i,
  output wtp_pkg::cam_t             head_o,
  output logic                      empty_o,
  output logic [wtp_pkg::QCntW-1:0] count_o
);

  localparam int unsigned QCntW = wtp_pkg::QCntW;

  wtp_pkg::cam_t               mem_q [wtp_pkg::QDepth];
  logic [wtp_pkg::QPtrW-1:0]   wr_q, rd_q;
  logic [wtp_pkg::QCntW-1:0]   cnt_q;

  assign head_o = mem_q[rd_q];
  assign empty_o = cnt_q == '0;
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  `WTP_ASSERT(fifo_no_overflow, push_i |-> (32'(cnt_q) < wtp_pkg::QDepth), "queue overflow")
  `WTP_ASSERT(fifo_no_underflow, pop_i |-> !empty_o, "queue underflow")
  `WTP_ASSERT(fifo_count_step, push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1, "queue count did not rise on push")

endmodule

// ===== rtl/wtp_back.sv =====
// Back end: focal scaling, pipelined division, principal point and output register.
`include "world_to_pixel_projection_macros.svh"
module wtp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wtp_pkg::cam_t      head_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  logic [30:0]        focal_x_i,
  input  logic [30:0]        focal_y_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pixel_u_o,
  output logic signed [31:0] pixel_v_o,
  output logic               invalid_o
);

  localparam int unsigned NS = wtp_pkg::NumW;
  localparam int unsigned DivW = wtp_pkg::DivW;

  logic                       en;
  logic                       v_q    [NS+1];
  logic [wtp_pkg::NumW-1:0]   nx_q   [NS+1];
  logic [wtp_pkg::NumW-1:0]   ny_q   [NS+1];
  logic [wtp_pkg::DivW-1:0]   rx_q   [NS+1];
  logic [wtp_pkg::DivW-1:0]   ry_q   [NS+1];
  logic [wtp_pkg::DivW-1:0]   d_q    [NS+1];
  logic                       negx_q [NS+1];
  logic                       negy_q [NS+1];
  logic                       bad_q  [NS+1];
  logic                       npos_q [NS+1];
  logic [31:0]                magx, magy;
  logic                       npos;
  logic signed [65:0]         su, sv;
  logic [32:0]                satu, satv;
  logic                       out_v_q;
  logic signed [31:0]         pix_u_q, pix_v_q;
  logic                       bad_out_q;

  assign en = !out_v_q || out_ready_i;
  assign pop_o = en && !empty_i;
  assign magx = head_i.cx[31] ? 32'(-head_i.cx) : 32'(head_i.cx);
  assign magy = head_i.cy[31] ? 32'(-head_i.cy) : 32'(head_i.cy);
  assign npos = head_i.cz[31] || head_i.cz == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q[0]   <= 63'(focal_x_i) * 63'(magx);
      ny_q[0]   <= 63'(focal_y_i) * 63'(magy);
      rx_q[0]   <= '0;
      ry_q[0]   <= '0;
      d_q[0]    <= npos ? 31'd1 : head_i.cz[30:0];
      negx_q[0] <= head_i.cx[31];
      negy_q[0] <= head_i.cy[31];
      bad_q[0]  <= head_i.bad;
      npos_q[0] <= npos;
    end
  end

  // One quotient bit per stage, restoring division on the magnitudes.
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [wtp_pkg::DivW:0] shx, shy;
    logic                   gex, gey;
    assign shx = {rx_q[k], nx_q[k][NS-1]};
    assign shy = {ry_q[k], ny_q[k][NS-1]};
    assign gex = shx >= {1'b0, d_q[k]};
    assign gey = shy >= {1'b0, d_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[k+1]   <= gex ? DivW'(shx - {1'b0, d_q[k]}) : shx[DivW-1:0];
        ry_q[k+1]   <= gey ? DivW'(shy - {1'b0, d_q[k]}) : shy[DivW-1:0];
        nx_q[k+1]   <= {nx_q[k][NS-2:0], gex};
        ny_q[k+1]   <= {ny_q[k][NS-2:0], gey};
        d_q[k+1]    <= d_q[k];
        negx_q[k+1] <= negx_q[k];
        negy_q[k+1] <= negy_q[k];
        bad_q[k+1]  <= bad_q[k];
        npos_q[k+1] <= npos_q[k];
      end
    end
  end

  always_comb begin
    su = negx_q[NS] ? -66'(nx_q[NS]) : 66'(nx_q[NS]);
    sv = negy_q[NS] ? -66'(ny_q[NS]) : 66'(ny_q[NS]);
    su = su + 66'(center_x_i);
    sv = sv + 66'(center_y_i);
    satu = wtp_pkg::sat66(su);
    satv = wtp_pkg::sat66(sv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_u_q   <= npos_q[NS] ? '0 : satu[31:0];
      pix_v_q   <= npos_q[NS] ? '0 : satv[31:0];
      bad_out_q <= bad_q[NS] | npos_q[NS] | (!npos_q[NS] & (satu[32] | satv[32]));
    end
  end

  assign out_valid_o = out_v_q;
  assign pixel_u_o = pix_u_q;
  assign pixel_v_o = pix_v_q;
  assign invalid_o = bad_out_q;

  `WTP_ASSERT(back_npos_zero, en && v_q[NS] && npos_q[NS] |=> out_v_q && invalid_o && pix_u_q == '0 && pix_v_q == '0, "nonpositive depth must give zero pixels and invalid")
  `WTP_ASSERT(back_pop_feeds, pop_o |=> v_q[0], "popped item not in first stage")

endmodule

// ===== rtl/world_to_pixel_projection.sv =====
// Throughput: one item per cycle while the output is not stalled; a load item updates the pose and gives no result.
// The divider has 63 stages, one quotient bit per stage per lane.
// Reset clears all valid bits and loads the identity pose and default intrinsics.
// Top level: pinhole projection of world points into pixel coordinates.
module world_to_pixel_projection #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pose_index[3:0], pose_value[35:4], point_x[67:36], point_y[99:68],
  // point_z[131:100], zero padding above
  input  logic [135:0] s_axis_tdata,
  // operation
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_u[31:0], pixel_v[63:32]
  output logic [63:0]  m_axis_tdata,
  // invalid
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  logic [30:0]                focal_x_q, focal_y_q;
  logic signed [31:0]         center_x_q, center_y_q;
  logic                       push, pop, empty;
  wtp_pkg::cam_t              push_data, head;
  logic [wtp_pkg::QCntW-1:0]  q_count;
  logic signed [31:0]         pu, pv;
  logic                       inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 31'd32768000;
      focal_y_q  <= 31'd32768000;
      center_x_q <= 32'sd20971520;
      center_y_q <= 32'sd15728640;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wtp_pkg::RegFocalX:  focal_x_q  <= cfg_data_i[30:0];
        wtp_pkg::RegFocalY:  focal_y_q  <= cfg_data_i[30:0];
        wtp_pkg::RegCenterX: center_x_q <= cfg_data_i;
        wtp_pkg::RegCenterY: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser[0]),
    .pose_index_i (s_axis_tdata[3:0]),
    .pose_value_i (s_axis_tdata[35:4]),
    .point_x_i    (s_axis_tdata[67:36]),
    .point_y_i    (s_axis_tdata[99:68]),
    .point_z_i    (s_axis_tdata[131:100]),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  wtp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .count_o     (q_count)
  );

  wtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .focal_x_i   (focal_x_q),
    .focal_y_i   (focal_y_q),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_u_o   (pu),
    .pixel_v_o   (pv),
    .invalid_o   (inv)
  );

  assign m_axis_tdata = {pv, pu};
  assign m_axis_tuser = inv;

endmodule

// ===== tb/tb_world_to_pixel_projection.sv =====
// Self-checking testbench for the world to pixel projection block.
`timescale 1ns / 1ps

module tb_world_to_pixel_projection;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DrainCycles = 90;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 300;

  typedef struct {
    logic [31:0] u;
    logic [31:0] v;
    logic        inv;
  } pixel_t;

  // Tracks pose and intrinsics and holds the pixels still owed by the block.
  class pixel_scoreboard;
    logic signed [31:0] pose[wtp_pkg::PoseWords];
    longint focal_x, focal_y, center_x, center_y;
    pixel_t owed_pixels[$];
    int unsigned mismatches, loads, projections, invalids;
    bit ovf;

    function new();
      foreach (pose[i]) pose[i] = '0;
      pose[0] = 32'sd1 <<< FracBits;
      pose[5] = 32'sd1 <<< FracBits;
      pose[10] = 32'sd1 <<< FracBits;
      focal_x = 32768000;
      focal_y = 32768000;
      center_x = 20971520;
      center_y = 15728640;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        wtp_pkg::RegFocalX: focal_x = longint'({1'b0, data[30:0]});
        wtp_pkg::RegFocalY: focal_y = longint'({1'b0, data[30:0]});
        wtp_pkg::RegCenterX: center_x = longint'(signed'(data));
        wtp_pkg::RegCenterY: center_y = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) begin
        ovf = 1;
        return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        ovf = 1;
        return -64'sd2147483648;
      end
      return x;
    endfunction

    function void note_item(logic op, logic [3:0] idx, logic [31:0] val,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint pt[3];
      longint cam[3];
      longint acc;
      pixel_t e;
      if (op == wtp_pkg::OpLoad) begin
        loads++;
        if (idx < wtp_pkg::PoseWords) pose[idx] = signed'(val);
        return;
      end
      projections++;
      pt[0] = longint'(signed'(px));
      pt[1] = longint'(signed'(py));
      pt[2] = longint'(signed'(pz));
      ovf = 0;
      for (int r = 0; r < 3; r++) begin
        acc = longint'(pose[r * 4 + 3]);
        for (int j = 0; j < 3; j++)
          acc += (longint'(pose[r * 4 + j]) * pt[j]) >>> FracBits;
        cam[r] = clamp32(acc);
      end
      e.u = '0;
      e.v = '0;
      if (cam[2] <= 0) begin
        ovf = 1;
      end else begin
        e.u = 32'(clamp32(focal_x * cam[0] / cam[2] + center_x));
        e.v = 32'(clamp32(focal_y * cam[1] / cam[2] + center_y));
      end
      e.inv = ovf;
      if (ovf) invalids++;
      owed_pixels.push_back(e);
    endfunction

    function void check_pixel(logic [31:0] u, logic [31:0] v, logic inv);
      pixel_t e;
      if (owed_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected pixel u=%h v=%h inv=%b", u, v, inv);
        return;
      end
      e = owed_pixels.pop_front();
      if (u !== e.u || v !== e.v || inv !== e.inv) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel exp u=%h v=%h inv=%b got u=%h v=%h inv=%b",
                   e.u, e.v, e.inv, u, v, inv);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;

  pixel_scoreboard sb = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycles;

  world_to_pixel_projection #(.FRAC_BITS(FracBits)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_pixel(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0]);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_item(logic op, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, pz, py, px, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, idx, val, px, py, pz);
  endtask

  // Waits for every owed pixel, then lets trailing load items settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] any_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] modest(int unsigned span);
    return $urandom_range(2 * span) - span;
  endfunction

  // New values for some pose words, a burst of modest points, and now and then one item of extreme words.
  task automatic random_burst(ref int unsigned sent);
    logic [31:0] val;
    for (int w = 0; w < wtp_pkg::PoseWords; w++) begin
      if ($urandom_range(3) == 0) begin
        if (w == 11) val = $urandom_range(2000 << FracBits, 1 << FracBits);
        else if (w % 4 == 3) val = modest(200 << FracBits);
        else val = modest(2 << FracBits);
        push_item(wtp_pkg::OpLoad, 4'(w), val, $urandom, $urandom, $urandom);
        sent++;
      end
    end
    repeat ($urandom_range(12, 4)) begin
      push_item(wtp_pkg::OpProject, 4'($urandom), $urandom, modest(150 << FracBits),
                modest(150 << FracBits), modest(150 << FracBits));
      sent++;
    end
    if ($urandom_range(4) == 0) begin
      push_item(1'($urandom_range(1)), 4'($urandom), any_word(), any_word(), any_word(),
                any_word());
      sent++;
    end
  endtask

  initial begin
    int unsigned sent;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items against the reset intrinsics, first with the reset pose, then with pose loads between them.
    push_item(wtp_pkg::OpProject, 4'hf, 32'hffff_ffff, 0, 0, 32'h1_0000);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h1_0000, 32'h2_0000, 32'h4_0000);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h5_0000, 32'h5_0000, 0);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h5_0000, 32'h5_0000, 32'hffff_0000);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    for (int i = 12; i < 16; i++) push_item(wtp_pkg::OpLoad, 4'(i), 32'hffff_ffff, 0, 0, 0);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h3_0000, 32'h1_0000, 32'h2_0000);
    push_item(wtp_pkg::OpLoad, 3, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h10_0000, 0, 32'h1_0000);
    push_item(wtp_pkg::OpLoad, 3, 32'h8000_0000, 0, 0, 0);
    push_item(wtp_pkg::OpProject, 0, 0, 32'hfff0_0000, 0, 32'h1_0000);
    push_item(wtp_pkg::OpLoad, 3, 0, 0, 0, 0);
    push_item(wtp_pkg::OpLoad, 11, 32'h5_0000, 0, 0, 0);
    push_item(wtp_pkg::OpProject, 0, 0, 32'h1_8000, 32'hffff_0000, 0);
    push_item(wtp_pkg::OpLoad, 10, 32'hffff_0000, 0, 0, 0);
    push_item(wtp_pkg::OpProject, 0, 0, 0, 0, 32'h1_0000);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 81 : 0;
      recv_stall_pct = (phase == 0) ? 81 : (phase == 1) ? 33 : 0;
      if (phase == 1) begin
        write_reg(wtp_pkg::RegFocalX, 32'h7fff_ffff);
        write_reg(wtp_pkg::RegFocalY, 32'h0);
        write_reg(wtp_pkg::RegCenterX, 32'h8000_0000);
        write_reg(wtp_pkg::RegCenterY, 32'h7fff_ffff);
      end else begin
        write_reg(wtp_pkg::RegFocalX, $urandom_range(3000 << FracBits));
        write_reg(wtp_pkg::RegFocalY, $urandom_range(3000 << FracBits));
        write_reg(wtp_pkg::RegCenterX, modest(1000 << FracBits));
        write_reg(wtp_pkg::RegCenterY, modest(1000 << FracBits));
      end
      sent = 0;
      while (sent < ItemsPerPhase) random_burst(sent);
      drain();
    end

    $display("Covered %0d pose loads and %0d projections, %0d flagged invalid,",
             sb.loads, sb.projections, sb.invalids);
    $display("over reset, extreme and random intrinsics with varied flow control.");
    if (sb.mismatches == 0 && sb.owed_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
